/* rtl/compass_frame_parser_with_activation_defines.svh */
// Assertion macros shared by the compass parser checker.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef COMPASS_FRAME_PARSER_WITH_ACTIVATION_DEFINES_SVH
`define COMPASS_FRAME_PARSER_WITH_ACTIVATION_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define CFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define CFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cfp_pkg.sv */
// Types, constants and helper functions for the compass frame parser.
// No dependencies; used by every module of the block.
`default_nettype none

package cfp_pkg;

    // Protocol bytes
    localparam logic [7:0] HDR_BYTE       = 8'h5A;
    localparam logic [7:0] TYPE_ANGLE     = 8'h45;
    localparam logic [7:0] CMD_SYNC       = 8'hA5;
    localparam logic [7:0] CMD_START      = 8'h45;
    localparam logic [7:0] CMD_START_SUM  = 8'hEA;
    localparam logic [7:0] CMD_CAL_ACC    = 8'h51;
    localparam logic [7:0] CMD_CAL_ACC_S  = 8'hF6;
    localparam logic [7:0] CMD_CAL_GYRO   = 8'h52;
    localparam logic [7:0] CMD_CAL_GYRO_S = 8'hF7;
    localparam logic [7:0] CMD_CAL_MAG    = 8'h53;
    localparam logic [7:0] CMD_CAL_MAG_S  = 8'hF8;

    // Frame positions
    localparam logic [3:0] POS_HUNT       = 4'd0;
    localparam logic [3:0] POS_AFTER_HDR  = 4'd2;
    localparam logic [3:0] POS_TYPE       = 4'd2;
    localparam logic [3:0] POS_DATA_FIRST = 4'd4;
    localparam int         DATA_BYTES     = 6;
    localparam logic [3:0] POS_FRAME_END  = 4'd10;

    // Configuration
    localparam logic [15:0] TIMEOUT_RST   = 16'd2000;
    localparam logic [7:0]  THRESH_RST    = 8'd50;
    localparam logic        CFG_TIMEOUT   = 1'b0;
    localparam logic        CFG_THRESH    = 1'b1;
    localparam logic [7:0]  ACT_MAX       = 8'hFF;

    // Calibration selects
    localparam logic [1:0] SEL_ACC  = 2'd0;
    localparam logic [1:0] SEL_GYRO = 2'd1;
    localparam logic [1:0] SEL_MAG  = 2'd2;

    // Result kinds
    localparam logic KIND_ANGLE = 1'b0;
    localparam logic KIND_TX    = 1'b1;

    // Transmit beats within one command
    localparam logic [1:0] BEAT_SYNC = 2'd0;
    localparam logic [1:0] BEAT_CMD  = 2'd1;
    localparam logic [1:0] BEAT_SUM  = 2'd2;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        MODE_BYTE  = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_START = 2'd2,
        MODE_CAL   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        JOB_ANGLE    = 3'd0,
        JOB_START    = 3'd1,
        JOB_CAL_ACC  = 3'd2,
        JOB_CAL_GYRO = 3'd3,
        JOB_CAL_MAG  = 3'd4
    } t_job_op;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
        logic [1:0] command_select;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic [7:0]         tx_byte;
        logic               last;
    } t_out_item;

    typedef struct packed {
        t_job_op            op;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } t_job;

    typedef struct packed {
        logic        valid;
        logic        index;
        logic [15:0] data;
    } t_cfg_wr;

    // Byte sent on a given beat of a command job
    function automatic logic [7:0] cmd_byte(t_job_op op, logic [1:0] beat);
        logic [7:0] cmd;
        logic [7:0] sum;
        case (op)
            JOB_CAL_ACC: begin
                cmd = CMD_CAL_ACC;
                sum = CMD_CAL_ACC_S;
            end
            JOB_CAL_GYRO: begin
                cmd = CMD_CAL_GYRO;
                sum = CMD_CAL_GYRO_S;
            end
            JOB_CAL_MAG: begin
                cmd = CMD_CAL_MAG;
                sum = CMD_CAL_MAG_S;
            end
            default: begin
                cmd = CMD_START;
                sum = CMD_START_SUM;
            end
        endcase
        case (beat)
            BEAT_SYNC: cmd_byte = CMD_SYNC;
            BEAT_CMD:  cmd_byte = cmd;
            default:   cmd_byte = sum;
        endcase
    endfunction

endpackage

`default_nettype wire

/* rtl/cfp_front.sv */
// Front end: takes input items, runs the frame parser, activity count and
// timeout timer, and posts one job per productive item. Depends on cfp_pkg.
`default_nettype none

module cfp_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  cfp_pkg::t_in_item    i_item,
    input  cfp_pkg::t_cfg_wr     i_cfg,
    output logic                 o_job_vld,
    output cfp_pkg::t_job        o_job
);

    logic        r_prev_hdr, n_prev_hdr;
    logic [3:0]  r_pos, n_pos;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_data [cfp_pkg::DATA_BYTES];
    logic        r_running, n_running;
    logic [7:0]  r_act, n_act;
    logic [15:0] r_rem, n_rem;
    logic        r_armed, n_armed;
    logic [15:0] r_timeout;
    logic [7:0]  r_thresh;
    logic        byte_wr;

    // Next state of parser and timer
    always_comb begin
        n_prev_hdr = r_prev_hdr;
        n_pos      = r_pos;
        n_type     = r_type;
        n_running  = r_running;
        n_act      = r_act;
        n_rem      = r_rem;
        n_armed    = r_armed;
        byte_wr    = 1'b0;
        o_job_vld  = 1'b0;
        o_job.op    = cfp_pkg::JOB_START;
        o_job.roll  = {r_data[0], r_data[1]};
        o_job.pitch = {r_data[2], r_data[3]};
        o_job.yaw   = {r_data[4], r_data[5]};
        unique case (cfp_pkg::t_mode'(i_item.mode))
            cfp_pkg::MODE_BYTE: begin
                if (r_pos == cfp_pkg::POS_HUNT) begin
                    if (r_prev_hdr && i_item.rx_byte == cfp_pkg::HDR_BYTE) begin
                        n_prev_hdr = 1'b0;
                        n_pos      = cfp_pkg::POS_AFTER_HDR;
                    end else begin
                        if (!r_running && r_act != cfp_pkg::ACT_MAX) begin
                            n_act = r_act + 8'd1;
                        end
                        n_prev_hdr = (i_item.rx_byte == cfp_pkg::HDR_BYTE);
                    end
                end else begin
                    byte_wr = 1'b1;
                    if (r_pos == cfp_pkg::POS_TYPE) begin
                        n_type = i_item.rx_byte;
                    end
                    if (r_pos >= cfp_pkg::POS_FRAME_END) begin
                        n_pos      = cfp_pkg::POS_HUNT;
                        n_prev_hdr = 1'b0;
                        if (r_type == cfp_pkg::TYPE_ANGLE) begin
                            o_job_vld = 1'b1;
                            o_job.op  = cfp_pkg::JOB_ANGLE;
                        end
                    end else begin
                        n_pos = r_pos + 4'd1;
                    end
                end
            end
            cfp_pkg::MODE_TICK: begin
                if (r_armed) begin
                    if (r_rem > 16'd1) begin
                        n_rem = r_rem - 16'd1;
                    end else if (r_act < r_thresh) begin
                        // timeout with too little traffic: restart
                        n_act     = '0;
                        n_rem     = r_timeout;
                        o_job_vld = 1'b1;
                    end else begin
                        n_armed   = 1'b0;
                        n_rem     = '0;
                        n_running = 1'b1;
                        n_act     = '0;
                    end
                end
            end
            cfp_pkg::MODE_START: begin
                n_rem     = r_timeout;
                n_armed   = 1'b1;
                o_job_vld = 1'b1;
            end
            cfp_pkg::MODE_CAL: begin
                case (i_item.command_select)
                    cfp_pkg::SEL_ACC: begin
                        o_job_vld = 1'b1;
                        o_job.op  = cfp_pkg::JOB_CAL_ACC;
                    end
                    cfp_pkg::SEL_GYRO: begin
                        o_job_vld = 1'b1;
                        o_job.op  = cfp_pkg::JOB_CAL_GYRO;
                    end
                    cfp_pkg::SEL_MAG: begin
                        o_job_vld = 1'b1;
                        o_job.op  = cfp_pkg::JOB_CAL_MAG;
                    end
                    default: begin
                        o_job_vld = 1'b0;
                    end
                endcase
            end
        endcase
        if (!i_accept) begin
            o_job_vld = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_hdr <= 1'b0;
            r_pos      <= cfp_pkg::POS_HUNT;
            r_type     <= '0;
            r_running  <= 1'b0;
            r_act      <= '0;
            r_rem      <= '0;
            r_armed    <= 1'b0;
        end else if (i_accept) begin
            r_prev_hdr <= n_prev_hdr;
            r_pos      <= n_pos;
            r_type     <= n_type;
            r_running  <= n_running;
            r_act      <= n_act;
            r_rem      <= n_rem;
            r_armed    <= n_armed;
        end
    end

    // Frame data bytes, written by position
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < cfp_pkg::DATA_BYTES; i++) begin
            if (i_accept && byte_wr && r_pos == cfp_pkg::POS_DATA_FIRST + 4'(i)) begin
                r_data[i] <= i_item.rx_byte;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= cfp_pkg::TIMEOUT_RST;
            r_thresh  <= cfp_pkg::THRESH_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                cfp_pkg::CFG_TIMEOUT: r_timeout <= i_cfg.data;
                default:              r_thresh  <= i_cfg.data[7:0];
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/cfp_queue.sv */
// Job queue between the front end and the result sequencer.
// Depends on cfp_pkg for the job type.
`default_nettype none

module cfp_queue #(
    parameter int DEPTH = cfp_pkg::QUEUE_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  cfp_pkg::t_job  i_wdata,
    output logic           o_full,
    output logic           o_valid,
    output cfp_pkg::t_job  o_rdata,
    input  wire logic      i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cfp_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/cfp_back.sv */
// Result sequencer: expands queued jobs into result beats and holds the
// oldest one in an output register. Depends on cfp_pkg.
`default_nettype none

module cfp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_vld,
    input  cfp_pkg::t_job      i_job,
    output logic               o_job_pop,
    output logic               o_empty,
    output cfp_pkg::t_out_item o_item,
    input  wire logic          i_pop
);

    logic               r_out_vld;
    cfp_pkg::t_out_item r_out, n_out;
    logic [1:0]         r_beat;
    logic               load;
    logic               is_last;

    assign load      = i_job_vld && (!r_out_vld || i_pop);
    assign is_last   = (i_job.op == cfp_pkg::JOB_ANGLE) || (r_beat == cfp_pkg::BEAT_SUM);
    assign o_job_pop = load && is_last;
    assign o_empty   = !r_out_vld;
    assign o_item    = r_out;

    // Build the beat for the head job
    always_comb begin
        n_out.last = is_last;
        if (i_job.op == cfp_pkg::JOB_ANGLE) begin
            n_out.kind    = cfp_pkg::KIND_ANGLE;
            n_out.roll    = i_job.roll;
            n_out.pitch   = i_job.pitch;
            n_out.yaw     = i_job.yaw;
            n_out.tx_byte = '0;
        end else begin
            n_out.kind    = cfp_pkg::KIND_TX;
            n_out.roll    = '0;
            n_out.pitch   = '0;
            n_out.yaw     = '0;
            n_out.tx_byte = cfp_pkg::cmd_byte(i_job.op, r_beat);
        end
    end

    // Advance beat counter and output flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_beat    <= cfp_pkg::BEAT_SYNC;
        end else begin
            if (load) begin
                r_out_vld <= 1'b1;
                r_beat    <= is_last ? cfp_pkg::BEAT_SYNC : r_beat + 2'd1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Hold the output beat
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

/* rtl/compass_frame_parser_with_activation.sv */
// Top level of the compass frame parser with activation handshake.
// Depends on cfp_pkg, cfp_front, cfp_queue and cfp_back.
//
// One input item is taken per cycle while the job queue (QUEUE_DEPTH entries)
// has room; the front end settles each item in that cycle. A received
// angle frame yields one result beat, a start, restart or calibration yields
// three transmit beats, and the result sequencer delivers one beat per cycle
// while the receiver pops, so a stream of command items is held back by its
// three beats each and other items are not. The first beat of an item is
// written to the queue on the edge that takes it and then into the output
// register, from which it can be popped. Config writes are taken every cycle.
`default_nettype none

module compass_frame_parser_with_activation #(
    parameter int QUEUE_DEPTH = cfp_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  cfp_pkg::t_in_item  i_in_item,
    output logic               empty,
    input  wire logic          pop,
    output cfp_pkg::t_out_item o_out_item,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic          i_cfg_index,
    input  wire logic [15:0]   i_cfg_data
);

    logic             accept;
    logic             job_vld;
    cfp_pkg::t_job    job;
    logic             q_valid;
    cfp_pkg::t_job    q_head;
    logic             q_pop;
    cfp_pkg::t_cfg_wr cfg;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    cfp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (i_in_item),
        .i_cfg     (cfg),
        .o_job_vld (job_vld),
        .o_job     (job)
    );

    cfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_vld),
        .i_wdata (job),
        .o_full  (full),
        .o_valid (q_valid),
        .o_rdata (q_head),
        .i_pop   (q_pop)
    );

    cfp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job_vld (q_valid),
        .i_job     (q_head),
        .o_job_pop (q_pop),
        .o_empty   (empty),
        .o_item    (o_out_item),
        .i_pop     (pop)
    );

endmodule

`default_nettype wire

/* rtl/cfp_checker.sv */
// Port-level checks for the compass frame parser, bound to the top level.
// Depends on cfp_pkg and the assertion macro header.
`default_nettype none

`include "compass_frame_parser_with_activation_defines.svh"

module cfp_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               empty,
    input wire logic               pop,
    input wire cfp_pkg::t_out_item o_out_item
);

    // A stalled beat stays put
    `CFP_ASSERT_NEXT(a_hold_beat, !empty && !pop, !empty && $stable(o_out_item), "beat changed while stalled")

    // An angle beat ends its run and carries no transmit byte
    `CFP_ASSERT_NOW(a_angle_form, !empty && o_out_item.kind == cfp_pkg::KIND_ANGLE, o_out_item.last && o_out_item.tx_byte == 8'h00, "bad angle beat")

    // A transmit beat carries zero angles
    `CFP_ASSERT_NOW(a_tx_form, !empty && o_out_item.kind == cfp_pkg::KIND_TX, o_out_item.roll == 16'sd0 && o_out_item.pitch == 16'sd0 && o_out_item.yaw == 16'sd0, "bad transmit beat")

    // A command keeps streaming until its last byte
    `CFP_ASSERT_NEXT(a_cmd_cont, !empty && pop && !o_out_item.last, !empty && o_out_item.kind == cfp_pkg::KIND_TX, "command run broken")

endmodule

bind compass_frame_parser_with_activation cfp_checker u_cfp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .empty      (empty),
    .pop        (pop),
    .o_out_item (o_out_item)
);

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for compass_frame_parser_with_activation: directed and random traffic,
// with an in-line predictor of every result beat. Depends on cfp_pkg and the block's RTL.
module tb_top;
    import cfp_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int MAX_GAP       = 40;
    localparam logic [1:0] SEL_UNUSED = 2'd3;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        full;
    t_in_item    i_in_item   = '0;
    logic        empty;
    logic        pop         = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data  = '0;

    // Predictor copy of the registers and parser / activation state
    logic [15:0] cfg_timeout = TIMEOUT_RST;
    logic [7:0]  cfg_thresh  = THRESH_RST;
    logic        hdr_seen    = 1'b0;
    logic [3:0]  frame_pos   = POS_HUNT;
    logic [7:0]  frame_kind  = '0;
    logic [7:0]  frame_bytes [DATA_BYTES] = '{default: '0};
    logic        dev_running = 1'b0;
    logic [7:0]  activity    = '0;
    logic [15:0] ticks_left  = '0;
    logic        timer_on    = 1'b0;

    t_out_item pending_beats [$];
    int mismatches    = 0;
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int stall_request = 0;
    int cycle_count   = 0;

    compass_frame_parser_with_activation uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin : clock_gen
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic void queue_tx_beat(logic [7:0] b, logic fin);
        t_out_item beat;
        beat         = '0;
        beat.kind    = KIND_TX;
        beat.tx_byte = b;
        beat.last    = fin;
        pending_beats.push_back(beat);
    endfunction

    function automatic void queue_command(logic [7:0] cmd, logic [7:0] sum);
        queue_tx_beat(CMD_SYNC, 1'b0);
        queue_tx_beat(cmd, 1'b0);
        queue_tx_beat(sum, 1'b1);
    endfunction

    // Load the timer and send the start command
    function automatic void arm_start();
        ticks_left = cfg_timeout;
        timer_on   = 1'b1;
        queue_command(CMD_START, CMD_START_SUM);
    endfunction

    function automatic void take_rx_byte(logic [7:0] b);
        t_out_item beat;
        int slot;
        // Hunt: a second header byte opens a frame, anything else counts as activity until running or saturated
        if (frame_pos == POS_HUNT) begin
            if (hdr_seen && b == HDR_BYTE) begin
                hdr_seen  = 1'b0;
                frame_pos = POS_AFTER_HDR;
                return;
            end
            if (!dev_running && activity != ACT_MAX)
                activity = activity + 8'd1;
            hdr_seen = (b == HDR_BYTE);
            return;
        end
        // Collect type and data bytes
        slot = int'(frame_pos) - int'(POS_DATA_FIRST);
        if (frame_pos == POS_TYPE)
            frame_kind = b;
        else if (slot >= 0 && slot < DATA_BYTES)
            frame_bytes[slot] = b;
        if (frame_pos != POS_FRAME_END) begin
            frame_pos = frame_pos + 4'd1;
            return;
        end
        // Frame end: emit angles for the angle type only
        frame_pos = POS_HUNT;
        hdr_seen  = 1'b0;
        if (frame_kind == TYPE_ANGLE) begin
            beat       = '0;
            beat.kind  = KIND_ANGLE;
            beat.roll  = {frame_bytes[0], frame_bytes[1]};
            beat.pitch = {frame_bytes[2], frame_bytes[3]};
            beat.yaw   = {frame_bytes[4], frame_bytes[5]};
            beat.last  = 1'b1;
            pending_beats.push_back(beat);
        end
    endfunction

    function automatic void take_tick();
        if (!timer_on)
            return;
        if (ticks_left > 16'd1) begin
            ticks_left = ticks_left - 16'd1;
            return;
        end
        // Timeout: restart on too little activity, else declare running
        timer_on   = 1'b0;
        ticks_left = '0;
        if (activity < cfg_thresh) begin
            activity = '0;
            arm_start();
        end else begin
            dev_running = 1'b1;
            activity    = '0;
        end
    endfunction

    function automatic void predict_beats(t_in_item it);
        case (it.mode)
            MODE_BYTE:  take_rx_byte(it.rx_byte);
            MODE_TICK:  take_tick();
            MODE_START: arm_start();
            default: begin
                case (it.command_select)
                    SEL_ACC:  queue_command(CMD_CAL_ACC, CMD_CAL_ACC_S);
                    SEL_GYRO: queue_command(CMD_CAL_GYRO, CMD_CAL_GYRO_S);
                    SEL_MAG:  queue_command(CMD_CAL_MAG, CMD_CAL_MAG_S);
                    default:  ;
                endcase
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking and receiver stalls
    // ------------------------------------------------------------------
    function automatic void note_mismatch(string what, t_out_item want, t_out_item got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t %s: expected kind=%0d roll=%0d pitch=%0d yaw=%0d tx=%02h last=%0d",
                     $time, what, want.kind, $signed(want.roll), $signed(want.pitch),
                     $signed(want.yaw), want.tx_byte, want.last);
        if (mismatches <= MAX_REPORTS)
            $display("%0t %s:      got kind=%0d roll=%0d pitch=%0d yaw=%0d tx=%02h last=%0d",
                     $time, what, got.kind, $signed(got.roll), $signed(got.pitch),
                     $signed(got.yaw), got.tx_byte, got.last);
    endfunction

    initial begin : result_checker
        int hold_left;
        t_out_item want;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            // Compare each accepted beat with the oldest prediction
            if (i_rst_n && pop && !empty) begin
                if (pending_beats.size() == 0) begin
                    note_mismatch("unexpected beat", '0, o_out_item);
                end else begin
                    want = pending_beats.pop_front();
                    if (o_out_item.kind !== want.kind || o_out_item.roll !== want.roll ||
                        o_out_item.pitch !== want.pitch || o_out_item.yaw !== want.yaw ||
                        o_out_item.tx_byte !== want.tx_byte || o_out_item.last !== want.last)
                        note_mismatch("beat mismatch", want, o_out_item);
                end
            end
            // Hold off for a requested stretch, else stall at random
            if (stall_request > 0) begin
                hold_left     = stall_request;
                stall_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Offer one item after a random gap; predict once it is taken
    task automatic send_item(t_in_item it);
        int gap;
        gap = 0;
        while (tx_idle_pct > 0 && gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (full);
        predict_beats(it);
    endtask

    task automatic send_byte(logic [7:0] b);
        t_in_item it;
        it.mode           = MODE_BYTE;
        it.rx_byte        = b;
        it.command_select = 2'($urandom);
        send_item(it);
    endtask

    task automatic send_ctrl(t_mode m, logic [1:0] sel);
        t_in_item it;
        it.mode           = m;
        it.rx_byte        = 8'($urandom);
        it.command_select = sel;
        send_item(it);
    endtask

    // Header, type, spare byte, three big-endian angles, checksum
    task automatic send_frame(logic [7:0] kind_byte, logic [47:0] angles);
        send_byte(HDR_BYTE);
        send_byte(HDR_BYTE);
        send_byte(kind_byte);
        send_byte(8'($urandom));
        for (int i = 5; i >= 0; i--)
            send_byte(angles[i*8 +: 8]);
        send_byte(8'($urandom));
    endtask

    // Drop push and wait for every predicted beat plus the pipeline tail
    task automatic drain();
        push <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic idx, logic [15:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_TIMEOUT)
            cfg_timeout = val;
        else
            cfg_thresh = val[7:0];
    endtask

    task automatic send_random_traffic(int n_items);
        int sent;
        int pick;
        int n;
        logic [7:0] b;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                send_frame(($urandom_range(99) < 85) ? TYPE_ANGLE : 8'($urandom),
                           48'({$urandom, $urandom}));
                sent += 11;
            end else if (pick < 62) begin
                // hunt noise, header bytes mixed in
                n = $urandom_range(1, 4);
                repeat (n) begin
                    b = ($urandom_range(4) == 0) ? HDR_BYTE : 8'($urandom);
                    send_byte(b);
                end
                sent += n;
            end else if (pick < 77) begin
                n = $urandom_range(1, 3);
                repeat (n) send_ctrl(MODE_TICK, 2'($urandom));
                sent += n;
            end else if (pick < 83) begin
                send_ctrl(MODE_START, 2'($urandom));
                sent++;
            end else if (pick < 93) begin
                send_ctrl(MODE_CAL, 2'($urandom_range(3)));
                sent++;
            end else begin
                // broken header: lone header byte followed by something else
                send_byte(HDR_BYTE);
                send_byte(8'($urandom_range(8'h5B, 8'hFF)));
                sent += 2;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_commands();
        send_ctrl(MODE_TICK, 2'($urandom));
        send_ctrl(MODE_CAL, SEL_ACC);
        send_ctrl(MODE_CAL, SEL_GYRO);
        send_ctrl(MODE_CAL, SEL_MAG);
        send_ctrl(MODE_CAL, SEL_UNUSED);
        send_ctrl(MODE_START, 2'($urandom));
        send_ctrl(MODE_START, 2'($urandom));
    endtask

    task automatic test_angle_frames();
        send_byte(8'hFF);
        send_byte(8'h00);
        send_frame(TYPE_ANGLE, {16'h8000, 16'h7FFF, 16'hFFFF});
    endtask

    // One-tick timeout with the highest threshold: every expiry restarts
    task automatic test_timer_expiry();
        write_register(CFG_TIMEOUT, 16'd1);
        write_register(CFG_THRESH, 16'd255);
        send_ctrl(MODE_START, 2'($urandom));
        send_ctrl(MODE_TICK, 2'($urandom));
        send_ctrl(MODE_TICK, 2'($urandom));
    endtask

    task automatic test_random_phase(logic [15:0] timeout, logic [7:0] thresh,
                                     int tx_pct, int rx_pct, int n_items);
        write_register(CFG_TIMEOUT, timeout);
        write_register(CFG_THRESH, {8'h00, thresh});
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        send_random_traffic(n_items);
    endtask

    // Enough hunt bytes to pin the activity count at its ceiling
    task automatic test_activity_saturation();
        logic [7:0] b;
        write_register(CFG_TIMEOUT, 16'd6);
        write_register(CFG_THRESH, 16'd255);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_ctrl(MODE_START, 2'($urandom));
        repeat (275) begin
            b = 8'($urandom);
            if (b == HDR_BYTE)
                b = ~b;
            send_byte(b);
        end
        repeat (8) send_ctrl(MODE_TICK, 2'($urandom));
    endtask

    // Receiver holds off while commands keep coming, so the block fills up
    task automatic test_full_pressure();
        write_register(CFG_TIMEOUT, 16'hFFFF);
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        stall_request = 150;
        repeat (12) send_ctrl(MODE_CAL, 2'($urandom_range(SEL_MAG)));
        send_frame(TYPE_ANGLE, 48'({$urandom, $urandom}));
    endtask

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_commands();
        test_angle_frames();
        test_timer_expiry();
        test_random_phase(16'd4, 8'd255, 0, 0, 30);
        test_random_phase(16'd0, 8'd200, 83, 0, 30);
        test_random_phase(16'd2, 8'd120, 0, 83, 30);
        test_activity_saturation();
        test_random_phase(16'd5, 8'd0, 34, 34, 30);
        test_full_pressure();
        drain();
        if (mismatches == 0 && pending_beats.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/cfp_pkg.sv
rtl/cfp_front.sv
rtl/cfp_queue.sv
rtl/cfp_back.sv
rtl/compass_frame_parser_with_activation.sv
rtl/cfp_checker.sv
bench/tb_top.sv
